// ===== rtl/core/lkv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_pkg
// shared types and constants for the lru key-value cache
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int KEY_W       = 14;
  localparam int VALUE_W     = 32;
  localparam int CAP_W       = 11;
  localparam int KEY_COUNT   = 16384;
  localparam int MAX_ENTRIES = 1024;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_LOOK,
    ST_DEC,
    ST_LINK,
    ST_APPEND,
    ST_APPEND2,
    ST_FIN,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/lkv_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module lkv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/lru_key_value_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache
// key-value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) carries cmd, key, value; one beat is one
//   get or put. output channel (out_valid/out_ready) returns one beat per
//   operation: hit, read_value, evicted, evicted_key.
//   cfg_we/cfg_wdata writes the capacity register; write only while idle.
//   one operation is in flight at a time. the time from acceptance to out_valid
//   depends on the path (a hit on the newest entry or a miss that stores
//   nothing, an insert into an empty or non-empty list, a touch, an eviction),
//   set by the chain of dependent accesses to the key map and the link rams.
//   in_ready rises in the same cycle as out_valid, so the next beat is accepted
//   only after the previous result has reached the output register.
//   a key count that is not a power of two below 16384 adds a key reduction
//   by repeated subtraction before the lookup.
//   after reset a clearing pass over all KEY_COUNT key map entries (16384 by default) wipes
//   the key map; in_ready stays low until it ends. capacity resets to 1024.
//   a finished result sits in the output register and the next beat can be
//   accepted meanwhile; the following result waits while the receiver stalls.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int KEY_COUNT   = lkv_pkg::KEY_COUNT,
  parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [lkv_pkg::CAP_W-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       cmd,
  input  logic [lkv_pkg::KEY_W-1:0]  key,
  input  logic [lkv_pkg::VALUE_W-1:0] value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       hit,
  output logic [lkv_pkg::VALUE_W-1:0] read_value,
  output logic                       evicted,
  output logic [lkv_pkg::KEY_W-1:0]  evicted_key
);
  import lkv_pkg::*;

  localparam int KW   = $clog2(KEY_COUNT);
  localparam int SW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int CAPW = (CW > CAP_W) ? CW : CAP_W;
  localparam int DW   = KEY_W + 21;
  localparam bit NEED_RED = (KEY_COUNT < (1 << KEY_W)) &&
                            ((KEY_COUNT & (KEY_COUNT - 1)) != 0);

  state_t state, state_next;

  logic [KW-1:0]      clr;
  logic [KEY_W-1:0]   rk;
  logic [3:0]         st;
  logic               cmd_r;
  logic [VALUE_W-1:0] val_r;
  logic               hit_r, evict_r, insert_r, ev_r;
  logic [VALUE_W-1:0] rd_r;
  logic [SW-1:0]      s_r, oldest, newest;
  logic [KW-1:0]      evk_r;
  logic [CW-1:0]      used;
  logic [CAP_W-1:0]   capacity;
  logic [KW-1:0]      k;

  // memory ports
  logic          map_we, val_we, ks_we, prv_we, nxt_we;
  logic [KW-1:0] map_waddr, val_waddr;
  logic [SW:0]   map_wdata, map_rdata;
  logic [VALUE_W-1:0] val_wdata, val_rdata;
  logic [SW-1:0] ks_waddr, prv_waddr, nxt_waddr, slot_raddr;
  logic [KW-1:0] ks_wdata, ks_rdata;
  logic [SW-1:0] prv_wdata, prv_rdata, nxt_wdata, nxt_rdata;

  lkv_ram #(.WIDTH(SW + 1), .DEPTH(KEY_COUNT)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(k), .rdata(map_rdata)
  );
  lkv_ram #(.WIDTH(VALUE_W), .DEPTH(KEY_COUNT)) u_val (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
    .raddr(k), .rdata(val_rdata)
  );
  lkv_ram #(.WIDTH(KW), .DEPTH(MAX_ENTRIES)) u_keys (
    .clk(clk), .we(ks_we), .waddr(ks_waddr), .wdata(ks_wdata),
    .raddr(slot_raddr), .rdata(ks_rdata)
  );
  lkv_ram #(.WIDTH(SW), .DEPTH(MAX_ENTRIES)) u_prev (
    .clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
    .raddr(slot_raddr), .rdata(prv_rdata)
  );
  lkv_ram #(.WIDTH(SW), .DEPTH(MAX_ENTRIES)) u_next (
    .clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
    .raddr(slot_raddr), .rdata(nxt_rdata)
  );

  logic [CAPW-1:0] cap_eff;
  logic            m_valid, hit_d, can_ins, touch_d, evict_d, ins_d, empty, out_free;
  logic [SW-1:0]   m_slot, s_d;
  logic [DW-1:0]   shifted;

  assign k        = KW'(rk);
  assign cap_eff  = (CAPW'(capacity) > CAPW'(MAX_ENTRIES)) ? CAPW'(MAX_ENTRIES)
                                                            : CAPW'(capacity);
  assign m_valid  = map_rdata[SW];
  assign m_slot   = map_rdata[SW-1:0];
  assign hit_d    = m_valid;
  assign can_ins  = (cmd_r == CMD_PUT) && (cap_eff != '0);
  assign touch_d  = hit_d && (m_slot != newest);
  assign ins_d    = !hit_d && can_ins;
  assign evict_d  = ins_d && (CAPW'(used) >= cap_eff);
  assign s_d      = hit_d ? m_slot : (evict_d ? oldest : SW'(used));
  // list empty once the victim is gone, only on the insert path
  assign empty    = insert_r && (used == '0);
  assign out_free = !out_valid || out_ready;
  assign shifted  = DW'(KEY_COUNT) << st;
  assign in_ready = (state == ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:   if (clr == KW'(KEY_COUNT - 1)) state_next = ST_IDLE;
      ST_IDLE:    if (in_valid) state_next = NEED_RED ? ST_REDUCE : ST_LOOK;
      ST_REDUCE:  if (st == '0) state_next = ST_LOOK;
      ST_LOOK:    state_next = ST_DEC;
      ST_DEC: begin
        if (touch_d || evict_d) state_next = ST_LINK;
        else if (ins_d)         state_next = ST_APPEND;
        else                    state_next = ST_DONE;
      end
      ST_LINK:    state_next = ST_APPEND;
      ST_APPEND:  state_next = empty ? ST_FIN : ST_APPEND2;
      ST_APPEND2: state_next = insert_r ? ST_FIN : ST_DONE;
      ST_FIN:     state_next = ST_DONE;
      ST_DONE:    if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_CLEAR;
    endcase
  end

  // memory controls
  always_comb begin
    map_we = 1'b0; map_waddr = k;   map_wdata = '0;
    val_we = 1'b0; val_waddr = k;   val_wdata = val_r;
    ks_we  = 1'b0; ks_waddr  = s_r; ks_wdata  = k;
    prv_we = 1'b0; prv_waddr = s_r; prv_wdata = s_r;
    nxt_we = 1'b0; nxt_waddr = s_r; nxt_wdata = s_r;
    slot_raddr = s_d;
    unique case (state)
      ST_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr;
      end
      ST_DEC: begin
        val_we = (hit_d && (cmd_r == CMD_PUT)) || ins_d;
      end
      ST_LINK: begin
        // unlink the slot, p and n come straight from the link rams
        map_we    = evict_r;
        map_waddr = ks_rdata;
        nxt_we    = (s_r != oldest);
        nxt_waddr = prv_rdata;
        nxt_wdata = nxt_rdata;
        prv_we    = (s_r != newest);
        prv_waddr = nxt_rdata;
        prv_wdata = prv_rdata;
      end
      ST_APPEND: begin
        prv_we = 1'b1;
        nxt_we = 1'b1;
        if (!empty) begin
          prv_wdata = newest;
          nxt_waddr = newest;
        end
      end
      ST_APPEND2: begin
        nxt_we = 1'b1;
      end
      ST_FIN: begin
        ks_we     = 1'b1;
        map_we    = 1'b1;
        map_wdata = {1'b1, s_r};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr       <= '0;
      oldest    <= '0;
      newest    <= '0;
      used      <= '0;
      capacity  <= CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) capacity <= cfg_wdata;
      if (out_valid && out_ready && (state != ST_DONE)) out_valid <= 1'b0;
      case (state)
        ST_CLEAR: clr <= clr + KW'(1);
        ST_LINK: begin
          if (s_r == oldest) oldest <= nxt_rdata;
          if (s_r == newest) newest <= prv_rdata;
          if (evict_r) used <= used - CW'(1);
        end
        ST_APPEND: begin
          if (empty) oldest <= s_r;
          newest <= s_r;
        end
        ST_FIN: used <= used + CW'(1);
        ST_DONE: if (out_free) out_valid <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          rk    <= key;
          cmd_r <= cmd;
          val_r <= value;
          st    <= 4'(KEY_W - 1);
        end
      end
      ST_REDUCE: begin
        if (DW'(rk) >= shifted) rk <= rk - KEY_W'(shifted);
        st <= st - 4'd1;
      end
      ST_DEC: begin
        hit_r    <= hit_d;
        rd_r     <= (hit_d && (cmd_r == CMD_GET)) ? val_rdata : '0;
        s_r      <= s_d;
        evict_r  <= evict_d;
        insert_r <= ins_d;
        ev_r     <= 1'b0;
        evk_r    <= '0;
      end
      ST_LINK: begin
        if (evict_r) begin
          ev_r  <= 1'b1;
          evk_r <= ks_rdata;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          hit         <= hit_r;
          read_value  <= rd_r;
          evicted     <= ev_r;
          evicted_key <= KEY_W'(evk_r);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== dv/lkv_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_checker
// watches the cache channels, predicts each result with its own lru list
// model and compares every output beat field by field against the oldest
// prediction
// ----------------------------------------------------------------------------
module lkv_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [lkv_pkg::CAP_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        cmd,
  input  logic [lkv_pkg::KEY_W-1:0]   key,
  input  logic [lkv_pkg::VALUE_W-1:0] value,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        hit,
  input  logic [lkv_pkg::VALUE_W-1:0] read_value,
  input  logic                        evicted,
  input  logic [lkv_pkg::KEY_W-1:0]   evicted_key,
  output int                          errors,
  output int                          pending
);
  import lkv_pkg::*;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] read_value;
    logic               evicted;
    logic [KEY_W-1:0]   evicted_key;
  } lookup_res_t;

  lookup_res_t        res_q[$];
  logic [CAP_W-1:0]   cap_reg;
  bit                 present[KEY_COUNT];
  logic [9:0]         slot_of[KEY_COUNT];
  logic [VALUE_W-1:0] data_of[KEY_COUNT];
  logic [KEY_W-1:0]   owner_of[MAX_ENTRIES];
  logic [9:0]         prv[MAX_ENTRIES];
  logic [9:0]         nxt[MAX_ENTRIES];
  logic [9:0]         oldest, newest;
  int                 used;

  assign pending = res_q.size();

  function automatic void unlink_entry(logic [9:0] s);
    logic [9:0] p, n;
    p = prv[s];
    n = nxt[s];
    if (s == oldest) oldest = n;
    else nxt[p] = n;
    if (s == newest) newest = p;
    else prv[n] = p;
  endfunction

  function automatic void make_newest(logic [9:0] s, int count);
    if (count == 0) begin
      oldest = s;
      newest = s;
      prv[s] = s;
      nxt[s] = s;
    end else begin
      nxt[newest] = s;
      prv[s] = newest;
      nxt[s] = s;
      newest = s;
    end
  endfunction

  function automatic lookup_res_t cache_access(logic c, logic [KEY_W-1:0] k,
                                               logic [VALUE_W-1:0] v);
    lookup_res_t r;
    int          lim;
    logic [9:0]  s;
    r = '0;
    lim = (cap_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap_reg);
    r.hit = present[k];
    if (present[k]) begin
      s = slot_of[k];
      if (s != newest) begin
        unlink_entry(s);
        make_newest(s, used - 1);
      end
      if (c == CMD_GET) r.read_value = data_of[k];
      else data_of[k] = v;
    end else if (c == CMD_PUT && lim > 0) begin
      if (used >= lim) begin
        s = oldest;
        r.evicted = 1'b1;
        r.evicted_key = owner_of[s];
        unlink_entry(s);
        present[owner_of[s]] = 1'b0;
        used--;
      end else begin
        s = used[9:0];
      end
      make_newest(s, used);
      used++;
      owner_of[s] = k;
      present[k] = 1'b1;
      slot_of[k] = s;
      data_of[k] = v;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, exp);
    errors++;
  endtask

  initial begin
    errors = 0;
    cap_reg = CAP_RESET;
    oldest = '0;
    newest = '0;
    used = 0;
  end

  always @(posedge clk) begin
    lookup_res_t e;
    if (!rst) begin
      if (cfg_we) cap_reg = cfg_wdata;
      if (out_valid && out_ready) begin
        if (res_q.size() == 0) begin
          report_mismatch("unexpected result beat", 64'(hit), 0);
        end else begin
          e = res_q.pop_front();
          if (hit !== e.hit) report_mismatch("hit", 64'(hit), 64'(e.hit));
          if (read_value !== e.read_value)
            report_mismatch("read_value", 64'(read_value), 64'(e.read_value));
          if (evicted !== e.evicted)
            report_mismatch("evicted", 64'(evicted), 64'(e.evicted));
          if (evicted_key !== e.evicted_key)
            report_mismatch("evicted_key", 64'(evicted_key), 64'(e.evicted_key));
        end
      end
      if (in_valid && in_ready) res_q.push_back(cache_access(cmd, key, value));
    end
  end

endmodule

// ===== dv/tb_lru_key_value_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache
// drives gets and puts through the cache over a series of capacity settings
// and idling patterns; the checker predicts and compares every result beat
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;
  import lkv_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [CAP_W-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               cmd = CMD_GET;
  logic [KEY_W-1:0]   key = '0;
  logic [VALUE_W-1:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               hit;
  logic [VALUE_W-1:0] read_value;
  logic               evicted;
  logic [KEY_W-1:0]   evicted_key;
  int                 errors;
  int                 pending;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lru_key_value_cache u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .key(key), .value(value),
    .out_valid(out_valid), .out_ready(out_ready), .hit(hit), .read_value(read_value),
    .evicted(evicted), .evicted_key(evicted_key)
  );

  lkv_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .key(key), .value(value),
    .out_valid(out_valid), .out_ready(out_ready), .hit(hit), .read_value(read_value),
    .evicted(evicted), .evicted_key(evicted_key), .errors(errors), .pending(pending)
  );

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // one beat; valid stays high into the next beat unless an idle gap is drawn
  task automatic send_op(logic c, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
    in_valid <= 1'b1;
    cmd <= c;
    key <= k;
    value <= v;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] c);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly a narrow window of keys so hits and evictions are common
  task automatic random_phase(int n, int span);
    logic [KEY_W-1:0] k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 15) k = KEY_W'($urandom);
      else k = KEY_W'(16'h1f00 + $urandom_range(span - 1));
      send_op(logic'($urandom_range(1)), k, $urandom);
    end
  endtask

  initial begin
    int          caps[9];
    int          spans[9];
    caps  = '{2, 0, 1, 2047, 3, 8, 1, 5, 1024};
    spans = '{6, 10, 4, 64, 8, 16, 12, 9, 40};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, misses, hits, updates, touching a non-newest entry
    send_op(CMD_GET, '0, '0);
    send_op(CMD_PUT, '0, '0);
    send_op(CMD_PUT, '1, '1);
    send_op(CMD_GET, '0, '1);
    send_op(CMD_GET, '1, '0);
    send_op(CMD_GET, 14'h0005, 32'hffff_ffff);
    send_op(CMD_PUT, '0, 32'h5a5a_a5a5);
    send_op(CMD_GET, '1, '0);
    send_op(CMD_GET, '0, '0);
    send_op(CMD_PUT, 14'h2aaa, 32'haaaa_5555);
    send_op(CMD_GET, 14'h1555, '0);
    set_capacity(1);
    // capacity lowered below the count: each new key evicts one oldest entry
    send_op(CMD_PUT, 14'h0100, 32'h1);
    send_op(CMD_PUT, 14'h0101, 32'h2);
    send_op(CMD_GET, 14'h0101, '0);
    send_op(CMD_PUT, 14'h0102, 32'h3);
    send_op(CMD_GET, '0, '0);

    for (int p = 0; p < 9; p++) begin
      set_capacity(CAP_W'(caps[p]));
      send_idle_pct  = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 3) ? 19 : 46) : 0;
      recv_stall_pct = (p % 4 == 2 || p % 4 == 3) ? ((p % 4 == 3) ? 19 : 46) : 0;
      random_phase(110, spans[p]);
    end

    drain();
    if (errors == 0) $display("lru_key_value_cache regression: pass");
    else $display("lru_key_value_cache regression: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("lru_key_value_cache regression: fail");
    $finish;
  end

endmodule
